### hw/rtl/adaptive_replacement_cache_unit_macros.svh
// ----------------------------------------------------------------------------
// adaptive replacement cache unit assertion macros
// Implication and next-cycle checks sampled on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_REPLACEMENT_CACHE_UNIT_MACROS_SVH
`define ADAPTIVE_REPLACEMENT_CACHE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define ARCU_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("arcu same-cycle check failed");
`define ARCU_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("arcu next-cycle check failed");
`else
`define ARCU_ASSERT_IMP(name, pre, post)
`define ARCU_ASSERT_NEXT(name, pre, post)
`endif

`endif

### hw/rtl/arcu_pkg.sv
// ----------------------------------------------------------------------------
// arcu_pkg
// Shared constants and types of the adaptive replacement cache unit.
// ----------------------------------------------------------------------------
`default_nettype none

package arcu_pkg;

  localparam int unsigned DEF_MAX_CAPACITY = 16;
  localparam int unsigned DEF_GHOST_DEPTH  = 32;
  localparam int unsigned DEF_KEY_BITS     = 16;
  localparam int unsigned DEF_VALUE_BITS   = 32;
  localparam int unsigned CFG_W            = 5;
  localparam int unsigned REQ_TYPE_W       = 2;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_GET     = 2'd0,
    REQ_PUT     = 2'd1,
    REQ_PEEK    = 2'd2,
    REQ_UNKNOWN = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ROW_HOLD,
    ROW_MOVE_IN,
    ROW_REMOVE
  } row_op_e;

  typedef enum logic [1:0] {
    PATH_MISS,
    PATH_B1,
    PATH_B2
  } put_path_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_DIV,
    ST_ADAPT,
    ST_EVICT,
    ST_FINISH,
    ST_RESP
  } ctrl_state_e;

endpackage

`default_nettype wire

### hw/rtl/arcu_if.sv
// ----------------------------------------------------------------------------
// arcu request and response channels
// Valid/ready channels carrying cache requests and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface arcu_req_if
  import arcu_pkg::*;
#(
  parameter int unsigned KEY_BITS   = DEF_KEY_BITS,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, req_type, key, value, input ready);
  modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface arcu_rsp_if
  import arcu_pkg::*;
#(
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [VALUE_BITS-1:0] read_value;

  modport source (output valid, found, read_value, input ready);
  modport sink   (input valid, found, read_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/arcu_cell.sv
// ----------------------------------------------------------------------------
// arcu_cell
// One list slot: holds a word, shifts from a neighbor and matches the key.
// ----------------------------------------------------------------------------
`default_nettype none

module arcu_cell
  import arcu_pkg::*;
#(
  parameter int unsigned PW        = 4,
  parameter int unsigned LW        = 5,
  parameter int unsigned KEY_BITS  = DEF_KEY_BITS,
  parameter int unsigned WORD_BITS = DEF_KEY_BITS + DEF_VALUE_BITS
) (
  input  logic                 clk_i,
  input  logic [PW-1:0]        idx_i,
  input  row_op_e              op_i,
  input  logic [PW-1:0]        pos_i,
  input  logic [LW-1:0]        len_i,
  input  logic [WORD_BITS-1:0] left_i,
  input  logic [WORD_BITS-1:0] right_i,
  input  logic [KEY_BITS-1:0]  key_i,
  output logic [WORD_BITS-1:0] word_o,
  output logic                 match_o
);

  logic [WORD_BITS-1:0] word_q, word_d;

  // move-in shifts slots up to pos toward the tail, remove closes the gap at pos
  always_comb begin
    word_d = word_q;
    case (op_i)
      ROW_MOVE_IN: begin
        if (idx_i <= pos_i) word_d = left_i;
      end
      ROW_REMOVE: begin
        if (idx_i >= pos_i) word_d = right_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o  = word_q;
  assign match_o = (LW'(idx_i) < len_i) && (word_q[WORD_BITS-1 -: KEY_BITS] == key_i);

endmodule

`default_nettype wire

### hw/rtl/arcu_row.sv
// ----------------------------------------------------------------------------
// arcu_row
// A recency-ordered list built as a chain of cells, head at slot 0.
// ----------------------------------------------------------------------------
`default_nettype none

module arcu_row
  import arcu_pkg::*;
#(
  parameter int unsigned DEPTH     = DEF_MAX_CAPACITY,
  parameter int unsigned KEY_BITS  = DEF_KEY_BITS,
  parameter int unsigned WORD_BITS = DEF_KEY_BITS + DEF_VALUE_BITS,
  localparam int unsigned PW       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned LW       = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  row_op_e              op_i,
  input  logic [PW-1:0]        pos_i,
  input  logic [LW-1:0]        len_i,
  input  logic [WORD_BITS-1:0] head_i,
  input  logic [KEY_BITS-1:0]  key_i,
  output logic                 hit_o,
  output logic [PW-1:0]        hit_pos_o,
  output logic [WORD_BITS-1:0] hit_word_o,
  output logic [WORD_BITS-1:0] lru_word_o
);

  logic [WORD_BITS-1:0] words [DEPTH];
  logic [DEPTH-1:0]     match;
  logic [LW-1:0]        lru_sel;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w;
    if (i == 0) begin : g_head
      assign left_w = head_i;
    end else begin : g_mid
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_w = words[i];
    end else begin : g_next
      assign right_w = words[i+1];
    end
    arcu_cell #(
      .PW(PW), .LW(LW), .KEY_BITS(KEY_BITS), .WORD_BITS(WORD_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .idx_i   (PW'(i)),
      .op_i    (op_i),
      .pos_i   (pos_i),
      .len_i   (len_i),
      .left_i  (left_w),
      .right_i (right_w),
      .key_i   (key_i),
      .word_o  (words[i]),
      .match_o (match[i])
    );
  end

  // most recent match wins
  always_comb begin
    hit_o      = 1'b0;
    hit_pos_o  = '0;
    hit_word_o = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_o      = 1'b1;
        hit_pos_o  = PW'(i);
        hit_word_o = words[i];
      end
    end
  end

  assign lru_sel    = len_i - LW'(1);
  assign lru_word_o = words[lru_sel[PW-1:0]];

endmodule

`default_nettype wire

### hw/rtl/arcu_div.sv
// ----------------------------------------------------------------------------
// arcu_div
// Restoring divider for ghost list length ratios, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module arcu_div
  import arcu_pkg::*;
#(
  parameter int unsigned W = 6
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quot_o
);

  localparam int unsigned CNTW = $clog2(W + 1);

  logic            busy_q, busy_d, done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    rem_q, rem_d, quot_q, quot_d, den_q, den_d;
  logic [W:0]      shifted, diff;
  logic            ge;

  assign shifted = {rem_q, quot_q[W-1]};
  assign diff    = shifted - (W+1)'(den_q);
  assign ge      = shifted >= (W+1)'(den_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(W);
      rem_d  = '0;
      quot_d = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d  = ge ? diff[W-1:0] : shifted[W-1:0];
      quot_d = {quot_q[W-2:0], ge};
      cnt_d  = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

### hw/rtl/adaptive_replacement_cache_unit.sv
// ----------------------------------------------------------------------------
// adaptive_replacement_cache_unit
// Key-value cache with adaptive replacement over four cell-chain lists.
// ----------------------------------------------------------------------------
// One request is in work at a time. A get, peek, put hit or unknown kind
// passes through accept, lookup in all four lists and the result register.
// A put that misses adds eviction and list insert; a put that hits a ghost
// list adds target update, eviction and list insert, and first waits on the
// bit-serial divider for the length ratio when the other ghost list is
// longer than the one that hit. The next request is taken while a result
// still waits in the output register.
`default_nettype none
`include "adaptive_replacement_cache_unit_macros.svh"

module adaptive_replacement_cache_unit
  import arcu_pkg::*;
#(
  parameter int unsigned MAX_CAPACITY = DEF_MAX_CAPACITY,
  parameter int unsigned GHOST_DEPTH  = DEF_GHOST_DEPTH,
  parameter int unsigned KEY_BITS     = DEF_KEY_BITS,
  parameter int unsigned VALUE_BITS   = DEF_VALUE_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  arcu_req_if.sink         req_i,
  arcu_rsp_if.source       rsp_o
);

  localparam int unsigned RPW = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
  localparam int unsigned RLW = $clog2(MAX_CAPACITY + 1);
  localparam int unsigned GPW = $clog2(GHOST_DEPTH);
  localparam int unsigned GLW = $clog2(GHOST_DEPTH + 1);
  localparam int unsigned WB  = KEY_BITS + VALUE_BITS;
  localparam int unsigned SW  = ((GLW > RLW) ? GLW : RLW) + 2;

  ctrl_state_e state_q, state_d;
  put_path_e   path_q, path_d;

  logic [REQ_TYPE_W-1:0] req_type_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [GLW-1:0]        gpos_q, gpos_d;
  logic                  ev_ghost_q, ev_ghost_d, div_need_q, div_need_d;
  logic                  res_found_q, res_found_d;
  logic [VALUE_BITS-1:0] res_value_q, res_value_d;
  logic [RLW-1:0]        p_q, p_d, cap_q, cap_d, t1_len_q, t1_len_d, t2_len_q, t2_len_d;
  logic [GLW-1:0]        b1_len_q, b1_len_d, b2_len_q, b2_len_d;
  logic                  out_valid_q, out_valid_d, out_found_q, out_found_d;
  logic [VALUE_BITS-1:0] out_value_q, out_value_d;

  row_op_e               t1_op, t2_op, b1_op, b2_op;
  logic [RPW-1:0]        t1_pos, t2_pos, t1_hit_pos, t2_hit_pos;
  logic [GPW-1:0]        b1_pos, b2_pos, b1_hit_pos, b2_hit_pos;
  logic [WB-1:0]         t1_head, t2_head, t1_hit_word, t2_hit_word, t1_lru_word, t2_lru_word;
  logic [KEY_BITS-1:0]   b1_head, b2_head;
  logic                  t1_hit, t2_hit, b1_hit, b2_hit;

  logic                  div_start, div_done;
  logic [GLW-1:0]        div_num, div_den, div_quot, delta;

  logic                  accept, full, from_t1, trim_b1, trim_b2, div_b1, div_b2, out_free;
  logic [RPW-1:0]        t1_push_pos, t2_push_pos;
  logic [GPW-1:0]        b1_push_pos, b2_push_pos;
  logic [RLW-1:0]        t1_push_len, t2_push_len;
  logic [GLW-1:0]        b1_push_len, b2_push_len, gpos_adj;
  logic signed [SW-1:0]  cap_s, p_s, t1_s, t2_s, b1_s, b2_s, delta_s, p_up, p_dn;

  // ---------------- list rows and divider ----------------

  arcu_row #(.DEPTH(MAX_CAPACITY), .KEY_BITS(KEY_BITS), .WORD_BITS(WB)) u_t1 (
    .clk_i(clk_i), .op_i(t1_op), .pos_i(t1_pos), .len_i(t1_len_q), .head_i(t1_head),
    .key_i(key_q), .hit_o(t1_hit), .hit_pos_o(t1_hit_pos), .hit_word_o(t1_hit_word),
    .lru_word_o(t1_lru_word)
  );

  arcu_row #(.DEPTH(MAX_CAPACITY), .KEY_BITS(KEY_BITS), .WORD_BITS(WB)) u_t2 (
    .clk_i(clk_i), .op_i(t2_op), .pos_i(t2_pos), .len_i(t2_len_q), .head_i(t2_head),
    .key_i(key_q), .hit_o(t2_hit), .hit_pos_o(t2_hit_pos), .hit_word_o(t2_hit_word),
    .lru_word_o(t2_lru_word)
  );

  arcu_row #(.DEPTH(GHOST_DEPTH), .KEY_BITS(KEY_BITS), .WORD_BITS(KEY_BITS)) u_b1 (
    .clk_i(clk_i), .op_i(b1_op), .pos_i(b1_pos), .len_i(b1_len_q), .head_i(b1_head),
    .key_i(key_q), .hit_o(b1_hit), .hit_pos_o(b1_hit_pos), .hit_word_o(),
    .lru_word_o()
  );

  arcu_row #(.DEPTH(GHOST_DEPTH), .KEY_BITS(KEY_BITS), .WORD_BITS(KEY_BITS)) u_b2 (
    .clk_i(clk_i), .op_i(b2_op), .pos_i(b2_pos), .len_i(b2_len_q), .head_i(b2_head),
    .key_i(key_q), .hit_o(b2_hit), .hit_pos_o(b2_hit_pos), .hit_word_o(),
    .lru_word_o()
  );

  arcu_div #(.W(GLW)) u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(div_num),
    .den_i(div_den), .done_o(div_done), .quot_o(div_quot)
  );

  // ---------------- decode ----------------

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  // pushing into a full list drops its tail slot
  assign t1_push_pos = (32'(t1_len_q) >= MAX_CAPACITY) ? RPW'(MAX_CAPACITY - 1)
                                                       : t1_len_q[RPW-1:0];
  assign t2_push_pos = (32'(t2_len_q) >= MAX_CAPACITY) ? RPW'(MAX_CAPACITY - 1)
                                                       : t2_len_q[RPW-1:0];
  assign b1_push_pos = (32'(b1_len_q) >= GHOST_DEPTH) ? GPW'(GHOST_DEPTH - 1)
                                                      : b1_len_q[GPW-1:0];
  assign b2_push_pos = (32'(b2_len_q) >= GHOST_DEPTH) ? GPW'(GHOST_DEPTH - 1)
                                                      : b2_len_q[GPW-1:0];
  assign t1_push_len = (32'(t1_len_q) >= MAX_CAPACITY) ? t1_len_q : t1_len_q + RLW'(1);
  assign t2_push_len = (32'(t2_len_q) >= MAX_CAPACITY) ? t2_len_q : t2_len_q + RLW'(1);
  assign b1_push_len = (32'(b1_len_q) >= GHOST_DEPTH) ? b1_len_q : b1_len_q + GLW'(1);
  assign b2_push_len = (32'(b2_len_q) >= GHOST_DEPTH) ? b2_len_q : b2_len_q + GLW'(1);

  assign cap_s   = $signed(SW'(cap_q));
  assign p_s     = $signed(SW'(p_q));
  assign t1_s    = $signed(SW'(t1_len_q));
  assign t2_s    = $signed(SW'(t2_len_q));
  assign b1_s    = $signed(SW'(b1_len_q));
  assign b2_s    = $signed(SW'(b2_len_q));
  assign delta   = div_need_q ? div_quot : GLW'(1);
  assign delta_s = $signed(SW'(delta));
  assign p_up    = p_s + delta_s;
  assign p_dn    = p_s - delta_s;

  assign full    = (t1_s + t2_s) >= cap_s;
  assign from_t1 = (t1_len_q != '0) &&
                   ((t1_len_q > p_q) || ((t1_len_q == p_q) && (path_q == PATH_B2)));
  assign trim_b1 = (b1_s > (cap_s - p_s)) && (b1_len_q != '0);
  assign trim_b2 = b2_s > p_s;
  assign div_b1  = b2_len_q > b1_len_q;
  assign div_b2  = b1_len_q > b2_len_q;
  // the ghost hit slides down one place when eviction pushed into the same list
  assign gpos_adj = gpos_q + GLW'(ev_ghost_q);

  // ---------------- next state ----------------

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_MATCH;
      end
      ST_MATCH: begin
        if (req_type_q == REQ_PUT && !t1_hit && !t2_hit) begin
          if (b1_hit) begin
            state_d = div_b1 ? ST_DIV : ST_ADAPT;
          end else if (b2_hit) begin
            state_d = div_b2 ? ST_DIV : ST_ADAPT;
          end else begin
            state_d = ST_EVICT;
          end
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_ADAPT;
      end
      ST_ADAPT:  state_d = ST_EVICT;
      ST_EVICT:  state_d = ST_FINISH;
      ST_FINISH: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- datapath control ----------------

  always_comb begin
    path_d      = path_q;
    gpos_d      = gpos_q;
    ev_ghost_d  = ev_ghost_q;
    div_need_d  = div_need_q;
    res_found_d = res_found_q;
    res_value_d = res_value_q;
    p_d         = p_q;
    cap_d       = cap_q;
    t1_len_d    = t1_len_q;
    t2_len_d    = t2_len_q;
    b1_len_d    = b1_len_q;
    b2_len_d    = b2_len_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_found_d = out_found_q;
    out_value_d = out_value_q;
    t1_op = ROW_HOLD;  t1_pos = '0; t1_head = {key_q, val_q};
    t2_op = ROW_HOLD;  t2_pos = '0; t2_head = {key_q, val_q};
    b1_op = ROW_HOLD;  b1_pos = '0; b1_head = t1_lru_word[WB-1 -: KEY_BITS];
    b2_op = ROW_HOLD;  b2_pos = '0; b2_head = t2_lru_word[WB-1 -: KEY_BITS];
    div_start = 1'b0;
    div_num   = b2_len_q;
    div_den   = b1_len_q;

    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        cap_d = RLW'(1);
      end else if (32'(cfg_wdata_i) > MAX_CAPACITY) begin
        cap_d = RLW'(MAX_CAPACITY);
      end else begin
        cap_d = RLW'(cfg_wdata_i);
      end
    end

    case (state_q)
      ST_MATCH: begin
        res_found_d = 1'b0;
        res_value_d = '0;
        case (req_type_q)
          REQ_GET, REQ_PEEK: begin
            if (t1_hit) begin
              res_found_d = 1'b1;
              res_value_d = t1_hit_word[VALUE_BITS-1:0];
              if (req_type_q == REQ_GET) begin
                t1_op    = ROW_REMOVE;
                t1_pos   = t1_hit_pos;
                t1_len_d = t1_len_q - RLW'(1);
                t2_op    = ROW_MOVE_IN;
                t2_pos   = t2_push_pos;
                t2_head  = {key_q, t1_hit_word[VALUE_BITS-1:0]};
                t2_len_d = t2_push_len;
              end
            end else if (t2_hit) begin
              res_found_d = 1'b1;
              res_value_d = t2_hit_word[VALUE_BITS-1:0];
              if (req_type_q == REQ_GET) begin
                t2_op   = ROW_MOVE_IN;
                t2_pos  = t2_hit_pos;
                t2_head = {key_q, t2_hit_word[VALUE_BITS-1:0]};
              end
            end
          end
          REQ_PUT: begin
            res_found_d = 1'b1;
            if (t1_hit) begin
              t1_op    = ROW_REMOVE;
              t1_pos   = t1_hit_pos;
              t1_len_d = t1_len_q - RLW'(1);
              t2_op    = ROW_MOVE_IN;
              t2_pos   = t2_push_pos;
              t2_len_d = t2_push_len;
            end else if (t2_hit) begin
              t2_op  = ROW_MOVE_IN;
              t2_pos = t2_hit_pos;
            end else if (b1_hit) begin
              path_d     = PATH_B1;
              gpos_d     = GLW'(b1_hit_pos);
              div_need_d = div_b1;
              div_start  = div_b1;
            end else if (b2_hit) begin
              path_d     = PATH_B2;
              gpos_d     = GLW'(b2_hit_pos);
              div_need_d = div_b2;
              div_start  = div_b2;
              div_num    = b1_len_q;
              div_den    = b2_len_q;
            end else begin
              path_d     = PATH_MISS;
              div_need_d = 1'b0;
            end
          end
          default: ;
        endcase
      end
      ST_ADAPT: begin
        if (path_q == PATH_B1) begin
          p_d = (p_up > cap_s) ? cap_q : p_up[RLW-1:0];
        end else if (path_q == PATH_B2) begin
          p_d = (p_dn < 0) ? '0 : p_dn[RLW-1:0];
        end
      end
      ST_EVICT: begin
        ev_ghost_d = 1'b0;
        if (full) begin
          if (from_t1 || t2_len_q == '0) begin
            if (t1_len_q != '0) begin
              t1_len_d   = t1_len_q - RLW'(1);
              b1_op      = ROW_MOVE_IN;
              b1_pos     = b1_push_pos;
              b1_len_d   = b1_push_len;
              ev_ghost_d = (path_q == PATH_B1);
            end
          end else begin
            t2_len_d   = t2_len_q - RLW'(1);
            b2_op      = ROW_MOVE_IN;
            b2_pos     = b2_push_pos;
            b2_len_d   = b2_push_len;
            ev_ghost_d = (path_q == PATH_B2);
          end
        end
      end
      ST_FINISH: begin
        case (path_q)
          PATH_MISS: begin
            if (trim_b1) b1_len_d = b1_len_q - GLW'(1);
            if (trim_b2) b2_len_d = b2_len_q - GLW'(1);
            t1_op    = ROW_MOVE_IN;
            t1_pos   = t1_push_pos;
            t1_len_d = t1_push_len;
          end
          PATH_B1: begin
            if (gpos_adj < b1_len_q) begin
              b1_op    = ROW_REMOVE;
              b1_pos   = gpos_adj[GPW-1:0];
              b1_len_d = b1_len_q - GLW'(1);
            end
            t2_op    = ROW_MOVE_IN;
            t2_pos   = t2_push_pos;
            t2_len_d = t2_push_len;
          end
          PATH_B2: begin
            if (gpos_adj < b2_len_q) begin
              b2_op    = ROW_REMOVE;
              b2_pos   = gpos_adj[GPW-1:0];
              b2_len_d = b2_len_q - GLW'(1);
            end
            t2_op    = ROW_MOVE_IN;
            t2_pos   = t2_push_pos;
            t2_len_d = t2_push_len;
          end
          default: ;
        endcase
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_value_d = res_value_q;
        end
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p_q         <= '0;
      cap_q       <= RLW'(MAX_CAPACITY);
      t1_len_q    <= '0;
      t2_len_q    <= '0;
      b1_len_q    <= '0;
      b2_len_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      p_q         <= p_d;
      cap_q       <= cap_d;
      t1_len_q    <= t1_len_d;
      t2_len_q    <= t2_len_d;
      b1_len_q    <= b1_len_d;
      b2_len_q    <= b2_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= req_i.req_type;
      key_q      <= req_i.key;
      val_q      <= req_i.value;
    end
    path_q      <= path_d;
    gpos_q      <= gpos_d;
    ev_ghost_q  <= ev_ghost_d;
    div_need_q  <= div_need_d;
    res_found_q <= res_found_d;
    res_value_q <= res_value_d;
    out_found_q <= out_found_d;
    out_value_q <= out_value_d;
  end

  assign req_i.ready      = (state_q == ST_IDLE);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.found      = out_found_q;
  assign rsp_o.read_value = out_value_q;

  // ---------------- checks ----------------

  `ARCU_ASSERT_NEXT(a_accept_starts_lookup, accept, state_q == ST_MATCH)
  `ARCU_ASSERT_IMP(a_div_done_while_waiting, div_done, state_q == ST_DIV)
  `ARCU_ASSERT_IMP(a_target_bounded, 1'b1, 32'(p_q) <= MAX_CAPACITY)
  `ARCU_ASSERT_IMP(a_ghost_bounded, 1'b1,
                   32'(b1_len_q) <= GHOST_DEPTH && 32'(b2_len_q) <= GHOST_DEPTH)

endmodule

`default_nettype wire

### dv/adaptive_replacement_cache_unit_test.sv
// ----------------------------------------------------------------------------
// adaptive_replacement_cache_unit_test
// Drives get, put, peek and unknown-kind requests into the adaptive replacement cache and
// checks each result against a cycle-free cache model built into the bench.
// ----------------------------------------------------------------------------
`default_nettype none

class arc_scoreboard;
  localparam int CAP_MAX = arcu_pkg::DEF_MAX_CAPACITY;
  localparam int GHOSTS  = arcu_pkg::DEF_GHOST_DEPTH;

  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
  } arc_result_t;

  logic [15:0] t1_key[$];
  logic [31:0] t1_val[$];
  logic [15:0] t2_key[$];
  logic [31:0] t2_val[$];
  logic [15:0] b1_key[$];
  logic [15:0] b2_key[$];
  int          target;
  int          cache_cap;
  arc_result_t pending[$];
  int          errors;

  function new();
    target    = 0;
    cache_cap = CAP_MAX;
    errors    = 0;
  endfunction

  function void set_capacity(logic [4:0] v);
    int c;
    c = v;
    if (c < 1) c = 1;
    if (c > CAP_MAX) c = CAP_MAX;
    cache_cap = c;
  endfunction

  function int find_key(ref logic [15:0] q[$], input logic [15:0] k);
    for (int i = 0; i < q.size(); i++) if (q[i] == k) return i;
    return -1;
  endfunction

  function void t2_front(logic [15:0] k, logic [31:0] v);
    int at;
    at = find_key(t2_key, k);
    if (at >= 0) begin
      t2_key.delete(at);
      t2_val.delete(at);
    end
    if (t2_key.size() >= CAP_MAX) begin
      void'(t2_key.pop_back());
      void'(t2_val.pop_back());
    end
    t2_key.push_front(k);
    t2_val.push_front(v);
  endfunction

  function void ghost_front(ref logic [15:0] q[$], input logic [15:0] k);
    int at;
    at = find_key(q, k);
    if (at >= 0) q.delete(at);
    if (q.size() >= GHOSTS) void'(q.pop_back());
    q.push_front(k);
  endfunction

  function void evict_one(bit b2_hit);
    int  n1;
    bit  from_t1;
    n1 = t1_key.size();
    from_t1 = n1 > 0 && (n1 > target || (n1 == target && b2_hit));
    if (from_t1 || t2_key.size() == 0) begin
      if (n1 > 0) begin
        void'(t1_val.pop_back());
        ghost_front(b1_key, t1_key.pop_back());
      end
    end else begin
      void'(t2_val.pop_back());
      ghost_front(b2_key, t2_key.pop_back());
    end
  endfunction

  function bit is_full();
    return (t1_key.size() + t2_key.size()) >= cache_cap;
  endfunction

  function void store(logic [15:0] k, logic [31:0] v);
    int at, n1, n2;
    n1 = b1_key.size();
    n2 = b2_key.size();
    at = find_key(t1_key, k);
    if (at >= 0) begin
      t1_key.delete(at);
      t1_val.delete(at);
      t2_front(k, v);
    end else if (find_key(t2_key, k) >= 0) begin
      t2_front(k, v);
    end else if (find_key(b1_key, k) >= 0) begin
      target += (n2 > n1) ? n2 / n1 : 1;
      if (target > cache_cap) target = cache_cap;
      if (is_full()) evict_one(1'b0);
      at = find_key(b1_key, k);
      if (at >= 0) b1_key.delete(at);
      t2_front(k, v);
    end else if (find_key(b2_key, k) >= 0) begin
      target -= (n1 > n2) ? n1 / n2 : 1;
      if (target < 0) target = 0;
      if (is_full()) evict_one(1'b1);
      at = find_key(b2_key, k);
      if (at >= 0) b2_key.delete(at);
      t2_front(k, v);
    end else begin
      if (is_full()) evict_one(1'b0);
      if (b1_key.size() > cache_cap - target && b1_key.size() > 0) void'(b1_key.pop_back());
      if (b2_key.size() > target && b2_key.size() > 0) void'(b2_key.pop_back());
      if (t1_key.size() >= CAP_MAX) begin
        void'(t1_key.pop_back());
        void'(t1_val.pop_back());
      end
      t1_key.push_front(k);
      t1_val.push_front(v);
    end
  endfunction

  // work out the result of an accepted request and update the cache image
  function void note_request(logic [1:0] kind, logic [15:0] k, logic [31:0] v);
    arc_result_t r;
    int          at;
    r = '0;
    if (kind == arcu_pkg::REQ_PUT) begin
      store(k, v);
      r.found = 1'b1;
    end else if (kind == arcu_pkg::REQ_GET || kind == arcu_pkg::REQ_PEEK) begin
      at = find_key(t1_key, k);
      if (at >= 0) begin
        r = {1'b1, t1_val[at]};
        if (kind == arcu_pkg::REQ_GET) begin
          t1_key.delete(at);
          t1_val.delete(at);
          t2_front(k, r.read_value);
        end
      end else begin
        at = find_key(t2_key, k);
        if (at >= 0) begin
          r = {1'b1, t2_val[at]};
          if (kind == arcu_pkg::REQ_GET) t2_front(k, r.read_value);
        end
      end
    end
    pending.push_back(r);
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_result(logic found, logic [31:0] rv);
    arc_result_t e;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result found=%0b value=%h", found, rv));
      return;
    end
    e = pending.pop_front();
    if (found !== e.found)
      report($sformatf("found %0b, expected %0b", found, e.found));
    if (rv !== e.read_value)
      report($sformatf("read_value %h, expected %h", rv, e.read_value));
  endtask
endclass

module adaptive_replacement_cache_unit_test;
  import arcu_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [4:0] cfg_wdata_i = '0;
  int         send_idle_pct = 18;
  int         recv_idle_pct = 68;
  int         stall_cycles = 0;
  bit         timed_out = 1'b0;
  arc_scoreboard board;

  arcu_req_if req_if ();
  arcu_rsp_if rsp_if ();

  adaptive_replacement_cache_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    req_if.valid    = 1'b0;
    req_if.req_type = '0;
    req_if.key      = '0;
    req_if.value    = '0;
    rsp_if.ready    = 1'b0;
    board = new();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (rsp_if.valid && rsp_if.ready) board.check_result(rsp_if.found, rsp_if.read_value);
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("adaptive_replacement_cache_unit regression: fail");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] kind, logic [15:0] k, logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.key      <= k;
    req_if.value    <= v;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    board.note_request(kind, k, v);
    req_if.valid <= 1'b0;
    // the block takes no request in the cycle after an accept
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [4:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    board.set_capacity(v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // keys mostly from a small pool so that hits, ghost hits and evictions are common
  task automatic random_requests(int count, int pool);
    logic [1:0]  kind;
    logic [15:0] k;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      kind = (pick < 45) ? REQ_PUT : (pick < 80) ? REQ_GET : (pick < 97) ? REQ_PEEK : REQ_UNKNOWN;
      k = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(pool - 1));
      send_request(kind, k, $urandom);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every kind, zero value hit, unknown kind
    send_request(REQ_GET, 16'h0000, 32'h0);
    send_request(REQ_PUT, 16'hffff, 32'hffffffff);
    send_request(REQ_PEEK, 16'hffff, 32'h0);
    send_request(REQ_GET, 16'hffff, 32'h0);
    send_request(REQ_PUT, 16'h0000, 32'h0);
    send_request(REQ_GET, 16'h0000, 32'h12345678);
    send_request(REQ_UNKNOWN, 16'hffff, 32'hffffffff);
    send_request(REQ_PUT, 16'hffff, 32'h5a5aa5a5);
    send_request(REQ_PEEK, 16'h1234, 32'h0);
    write_capacity(5'd0);
    // capacity one: misses evict, ghost hits adapt the target
    send_request(REQ_PUT, 16'd1, 32'd11);
    send_request(REQ_PUT, 16'd2, 32'd22);
    send_request(REQ_PUT, 16'd1, 32'd33);
    send_request(REQ_GET, 16'd1, 32'd0);
    send_request(REQ_PUT, 16'd3, 32'd44);
    send_request(REQ_PUT, 16'd1, 32'd55);
    send_request(REQ_PEEK, 16'd2, 32'd0);
    write_capacity(5'd31);
    random_requests(350, 40);
    write_capacity(5'd16);
    drain();  // sender holds off until every result is back
    random_requests(100, 24);
    write_capacity(5'd3);
    send_idle_pct = 68;
    recv_idle_pct = 18;
    random_requests(200, 12);
    write_capacity(5'd1);
    random_requests(150, 6);
    write_capacity(5'd8);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_requests(350, 30);
    drain();

    if (board.errors == 0) begin
      $display("adaptive_replacement_cache_unit regression: pass");
    end else begin
      $display("adaptive_replacement_cache_unit regression: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
